// ===== hw/rtl/stok_pkg.sv =====
package stok_pkg;

	// integer accumulator width and the width of an event's value field
	localparam int INT_BITS = 31;
	localparam int VAL_W    = 31;
	localparam int ACC_W    = INT_BITS + 4;

	localparam logic [INT_BITS-1:0] INT_TOP = {INT_BITS{1'b1}};
	localparam logic [3:0]          RADIX   = 4'd10;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// result queue depth
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		EV_INT  = 3'd0,
		EV_SYMC = 3'd1,
		EV_SYME = 3'd2,
		EV_STRC = 3'd3,
		EV_STRE = 3'd4,
		EV_EOI  = 3'd5,
		EV_ERR  = 3'd6
	} event_kind_t;

	typedef struct packed {
		event_kind_t      kind;
		logic [VAL_W-1:0] value;
		logic             last;
	} result_t;

	// what one scanned byte pushes into the result queue
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              room;
	} qstat_t;

endpackage

// ===== hw/rtl/stok_ifs.sv =====
interface stok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_mark;

	modport source (output valid, output char_in, output end_mark, input ready);
	modport sink (input valid, input char_in, input end_mark, output ready);
endinterface

interface stok_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [30:0] event_value;
	logic        last_of_step;

	modport source (output valid, output event_kind, output event_value, output last_of_step,
		input ready);
	modport sink (input valid, input event_kind, input event_value, input last_of_step,
		output ready);
endinterface

// ===== hw/rtl/stok_scan.sv =====
module stok_scan (
	input  logic           clk,
	input  logic           arst_n,
	stok_in_if.sink        script,
	input  logic           room,
	output stok_pkg::push_t push
);

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_INT  = 3'd1,
		M_SYM  = 3'd2,
		M_STR  = 3'd3,
		M_ERR  = 3'd4
	} mode_t;

	mode_t                         mode_q, mode_d;
	logic [stok_pkg::INT_BITS-1:0] accum_q, accum_d;
	logic                          valid_s1;
	logic [7:0]                    char_s1;
	logic                          end_s1;
	logic                          advance;

	logic                          is_digit, is_letter, is_space, is_quote, sym_char;
	logic [7:0]                    lower;
	logic [3:0]                    digit;
	logic [stok_pkg::ACC_W-1:0]    prod;

	// start-of-token decode
	mode_t                         st_mode;
	logic [stok_pkg::INT_BITS-1:0] st_accum;
	logic                          st_emit;
	stok_pkg::result_t             st_res;

	stok_pkg::result_t             res0, res1;
	logic [1:0]                    n;

	assign script.ready = !valid_s1 || room;
	assign advance      = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (script.valid && script.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (script.valid && script.ready) begin
			char_s1 <= script.char_in;
			end_s1  <= script.end_mark;
		end
	end

	always_comb begin
		is_digit  = char_s1 inside {[stok_pkg::CH_0 : stok_pkg::CH_9]};
		is_letter = char_s1 inside {[stok_pkg::CH_UA : stok_pkg::CH_UZ],
			[stok_pkg::CH_LA : stok_pkg::CH_LZ]};
		is_space  = char_s1 inside {stok_pkg::CH_SPACE, stok_pkg::CH_TAB,
			stok_pkg::CH_LF, stok_pkg::CH_CR};
		is_quote  = (char_s1 == stok_pkg::CH_QUOTE);
		sym_char  = is_letter || (char_s1 == stok_pkg::CH_COLON);
		lower     = (char_s1 inside {[stok_pkg::CH_UA : stok_pkg::CH_UZ]}) ?
			(char_s1 | stok_pkg::CASE_BIT) : char_s1;
		digit     = 4'(char_s1 - stok_pkg::CH_0);
	end

	// accum * 10 + digit, saturating at the top value
	assign prod = stok_pkg::ACC_W'(accum_q) * stok_pkg::ACC_W'(stok_pkg::RADIX)
		+ stok_pkg::ACC_W'(digit);

	always_comb begin
		st_accum = '0;
		st_emit  = 1'b0;
		st_res   = '{kind: stok_pkg::EV_ERR, value: '0, last: 1'b0};
		if (is_space) begin
			st_mode = M_IDLE;
		end else if (is_digit) begin
			st_mode  = M_INT;
			st_accum = stok_pkg::INT_BITS'(digit);
		end else if (is_letter) begin
			st_mode = M_SYM;
			st_emit = 1'b1;
			st_res  = '{kind: stok_pkg::EV_SYMC, value: stok_pkg::VAL_W'(lower), last: 1'b0};
		end else if (is_quote) begin
			st_mode = M_STR;
		end else begin
			st_mode = M_ERR;
			st_emit = 1'b1;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		accum_d = accum_q;
		n       = 2'd0;
		res0    = '{kind: stok_pkg::EV_ERR, value: '0, last: 1'b0};
		res1    = '{kind: stok_pkg::EV_EOI, value: '0, last: 1'b0};
		case (mode_q)
			M_IDLE, M_INT, M_SYM, M_STR: begin
				if (end_s1) begin
					accum_d = '0;
					mode_d  = M_IDLE;
					case (mode_q)
						M_INT: begin
							n    = 2'd2;
							res0 = '{kind: stok_pkg::EV_INT,
								value: stok_pkg::VAL_W'(accum_q), last: 1'b0};
						end
						M_SYM: begin
							n    = 2'd2;
							res0 = '{kind: stok_pkg::EV_SYME, value: '0, last: 1'b0};
						end
						M_STR: begin
							n      = 2'd1;
							mode_d = M_ERR;
						end
						default: begin
							n    = 2'd1;
							res0 = '{kind: stok_pkg::EV_EOI, value: '0, last: 1'b0};
						end
					endcase
				end else begin
					case (mode_q)
						M_INT: begin
							if (is_digit) begin
								accum_d = (prod > stok_pkg::ACC_W'(stok_pkg::INT_TOP)) ?
									stok_pkg::INT_TOP : stok_pkg::INT_BITS'(prod);
							end else begin
								res0    = '{kind: stok_pkg::EV_INT,
									value: stok_pkg::VAL_W'(accum_q), last: 1'b0};
								res1    = st_res;
								n       = st_emit ? 2'd2 : 2'd1;
								mode_d  = st_mode;
								accum_d = st_accum;
							end
						end
						M_SYM: begin
							if (sym_char) begin
								n    = 2'd1;
								res0 = '{kind: stok_pkg::EV_SYMC,
									value: stok_pkg::VAL_W'(lower), last: 1'b0};
							end else begin
								res0    = '{kind: stok_pkg::EV_SYME, value: '0, last: 1'b0};
								res1    = st_res;
								n       = st_emit ? 2'd2 : 2'd1;
								mode_d  = st_mode;
								accum_d = st_accum;
							end
						end
						M_STR: begin
							n = 2'd1;
							if (is_quote) begin
								res0   = '{kind: stok_pkg::EV_STRE, value: '0, last: 1'b0};
								mode_d = M_IDLE;
							end else begin
								res0 = '{kind: stok_pkg::EV_STRC,
									value: stok_pkg::VAL_W'(char_s1), last: 1'b0};
							end
						end
						default: begin
							res0    = st_res;
							n       = st_emit ? 2'd1 : 2'd0;
							mode_d  = st_mode;
							accum_d = st_accum;
						end
					endcase
				end
			end
			default: begin
				n      = 2'd1;
				mode_d = M_ERR;
			end
		endcase
		res0.last = (n == 2'd1);
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			accum_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
		end
	end

	assign push.n  = advance ? n : 2'd0;
	assign push.r0 = res0;
	assign push.r1 = res1;

endmodule

// ===== hw/rtl/stok_rfifo.sv =====
module stok_rfifo (
	input  logic             clk,
	input  logic             arst_n,
	input  stok_pkg::push_t  push,
	stok_out_if.source       events,
	output stok_pkg::qstat_t stat
);

	stok_pkg::result_t               mem [stok_pkg::QDEPTH];
	logic [stok_pkg::QPTR_W-1:0]     wr_q, rd_q, wr_next;
	logic [stok_pkg::QCNT_W-1:0]     count_q;
	logic                            pop;
	stok_pkg::result_t               head;

	assign wr_next = wr_q + stok_pkg::QPTR_W'(1);
	assign pop     = events.valid && events.ready;
	assign head    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + stok_pkg::QPTR_W'(push.n);
			rd_q    <= rd_q + stok_pkg::QPTR_W'(pop);
			count_q <= count_q + stok_pkg::QCNT_W'(push.n) - stok_pkg::QCNT_W'(pop);
		end
	end

	assign events.valid        = (count_q != '0);
	assign events.event_kind   = head.kind;
	assign events.event_value  = head.value;
	assign events.last_of_step = head.last;

	// room for the two results a byte may cause, judged on registered fill only
	assign stat.count = count_q;
	assign stat.room  = (count_q <= stok_pkg::QCNT_W'(stok_pkg::QDEPTH - 2));

endmodule

// ===== hw/rtl/script_token_scanner.sv =====
// channel  | dir | transaction payload
// ---------+-----+-------------------------------------------------
// script   | in  | char_in[7:0], end_mark
// events   | out | event_kind[2:0], event_value[30:0], last_of_step
//
// a script byte is registered, scanned combinationally, and its zero, one or two
// events land in a four-entry result queue
// sustained rate is one byte per cycle while each byte makes at most one event and
// events.ready stays high; a byte that makes two events needs two event transactions
// script.ready depends only on registered state (input register and queue fill), never on events.ready
// arst_n clears scanner mode, the integer accumulator and the queue pointers
module script_token_scanner (
	input  logic       clk,
	input  logic       arst_n,
	stok_in_if.sink    script,
	stok_out_if.source events
);

	stok_pkg::push_t  push;
	stok_pkg::qstat_t stat;

	// token scanner: input register, mode and accumulator update
	stok_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.script (script),
		.room   (stat.room),
		.push   (push)
	);

	// result queue, drains one event per transaction
	stok_rfifo u_rfifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.events (events),
		.stat   (stat)
	);

	// queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= stok_pkg::QCNT_W'(stok_pkg::QDEPTH))
		else $error("result queue overfilled");

	// a push only happens with room for two
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> stat.room)
		else $error("push without room");

	// the error mode is sticky: the next event shown after a taken error event is also an error event
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && events.ready && events.event_kind == stok_pkg::EV_ERR)
		|=> (!events.valid || events.event_kind == stok_pkg::EV_ERR))
		else $error("event after error is not an error");

endmodule

// ===== dv/script_token_scanner_tb.sv =====
module script_token_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// run length bounds: watchdog limit and quiet cycles once the queue is empty
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_ITEMS = 1250;
	// receiver hold-off used to fill the block up and stall the script side
	localparam int HOLD_START = 400;
	localparam int HOLD_LEN   = 160;

	// scanner mode tracked by the predictor
	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_INT,
		SCAN_SYM,
		SCAN_STR,
		SCAN_ERR
	} scan_mode_t;

	// how the closing stretch pushes the scanner into its sticky error
	typedef enum logic [1:0] {
		TRIG_OPEN_STRING,
		TRIG_ZERO_BYTE,
		TRIG_ILLEGAL,
		TRIG_COLON
	} err_trigger_t;

	// one script transaction waiting to be offered
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} script_item_t;

	logic clk;
	logic arst_n;

	stok_in_if  script_if ();
	stok_out_if events_if ();

	script_token_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.script (script_if.sink),
		.events (events_if.source)
	);

	script_item_t      pending_bytes[$];
	stok_pkg::result_t expected_events[$];
	stok_pkg::result_t step_events[$];

	// predictor state
	scan_mode_t  tok_mode;
	logic [30:0] tok_accum;

	int failures = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// token predictor
	// ---------------------------------------------------------------

	function automatic logic is_digit(logic [7:0] b);
		return b >= stok_pkg::CH_0 && b <= stok_pkg::CH_9;
	endfunction

	function automatic logic is_upper(logic [7:0] b);
		return b >= stok_pkg::CH_UA && b <= stok_pkg::CH_UZ;
	endfunction

	function automatic logic is_letter(logic [7:0] b);
		return is_upper(b) || (b >= stok_pkg::CH_LA && b <= stok_pkg::CH_LZ);
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b == stok_pkg::CH_SPACE || b == stok_pkg::CH_TAB ||
			b == stok_pkg::CH_LF || b == stok_pkg::CH_CR;
	endfunction

	function automatic void emit_event(stok_pkg::event_kind_t k, logic [30:0] v);
		stok_pkg::result_t r;
		r.kind  = k;
		r.value = v;
		r.last  = 1'b0;
		step_events.push_back(r);
	endfunction

	// a byte seen between tokens opens the next token
	function automatic void open_token(logic [7:0] b);
		if (is_space(b)) begin
			tok_mode = SCAN_IDLE;
		end else if (is_digit(b)) begin
			tok_mode  = SCAN_INT;
			tok_accum = 31'(b - stok_pkg::CH_0);
		end else if (is_letter(b)) begin
			tok_mode = SCAN_SYM;
			emit_event(stok_pkg::EV_SYMC,
				31'(is_upper(b) ? (b | stok_pkg::CASE_BIT) : b));
		end else if (b == stok_pkg::CH_QUOTE) begin
			tok_mode = SCAN_STR;
		end else begin
			tok_mode = SCAN_ERR;
			emit_event(stok_pkg::EV_ERR, '0);
		end
	endfunction

	// works out the events of one accepted script transaction
	function automatic void predict_tokens(logic [7:0] b, logic fin);
		logic [63:0] top;
		logic [63:0] digit;
		step_events.delete();
		top   = 64'(stok_pkg::INT_TOP);
		digit = 64'(b - stok_pkg::CH_0);
		if (tok_mode == SCAN_ERR) begin
			emit_event(stok_pkg::EV_ERR, '0);
		end else if (fin) begin
			case (tok_mode)
				SCAN_INT: begin
					emit_event(stok_pkg::EV_INT, tok_accum);
					emit_event(stok_pkg::EV_EOI, '0);
					tok_mode = SCAN_IDLE;
				end
				SCAN_SYM: begin
					emit_event(stok_pkg::EV_SYME, '0);
					emit_event(stok_pkg::EV_EOI, '0);
					tok_mode = SCAN_IDLE;
				end
				// script ends with a string still open
				SCAN_STR: begin
					emit_event(stok_pkg::EV_ERR, '0);
					tok_mode = SCAN_ERR;
				end
				default: begin
					emit_event(stok_pkg::EV_EOI, '0);
				end
			endcase
			tok_accum = '0;
		end else begin
			case (tok_mode)
				SCAN_INT: begin
					if (is_digit(b)) begin
						// saturate instead of wrapping
						if (64'(tok_accum) > (top - digit) / 64'(stok_pkg::RADIX))
							tok_accum = stok_pkg::INT_TOP;
						else
							tok_accum = 31'(64'(tok_accum) * 64'(stok_pkg::RADIX) + digit);
					end else begin
						emit_event(stok_pkg::EV_INT, tok_accum);
						tok_accum = '0;
						open_token(b);
					end
				end
				SCAN_SYM: begin
					if (is_letter(b) || b == stok_pkg::CH_COLON) begin
						emit_event(stok_pkg::EV_SYMC,
							31'(is_upper(b) ? (b | stok_pkg::CASE_BIT) : b));
					end else begin
						emit_event(stok_pkg::EV_SYME, '0);
						open_token(b);
					end
				end
				SCAN_STR: begin
					if (b == stok_pkg::CH_QUOTE) begin
						emit_event(stok_pkg::EV_STRE, '0);
						tok_mode = SCAN_IDLE;
					end else begin
						emit_event(stok_pkg::EV_STRC, 31'(b));
					end
				end
				default: begin
					open_token(b);
				end
			endcase
		end
		if (step_events.size() != 0)
			step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i])
			expected_events.push_back(step_events[i]);
	endfunction

	// ---------------------------------------------------------------
	// script builders
	// ---------------------------------------------------------------

	task automatic add_byte(logic [7:0] b);
		script_item_t it;
		it.ch  = b;
		it.fin = 1'b0;
		pending_bytes.push_back(it);
	endtask

	// end of script; the byte lane carries noise that must be ignored
	task automatic add_end();
		script_item_t it;
		it.ch  = 8'($urandom_range(0, 255));
		it.fin = 1'b1;
		pending_bytes.push_back(it);
	endtask

	task automatic add_letter();
		if ($urandom_range(0, 1) == 0)
			add_byte(stok_pkg::CH_UA + 8'($urandom_range(0, 25)));
		else
			add_byte(stok_pkg::CH_LA + 8'($urandom_range(0, 25)));
	endtask

	task automatic add_spaces();
		int n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: add_byte(stok_pkg::CH_SPACE);
				1: add_byte(stok_pkg::CH_TAB);
				2: add_byte(stok_pkg::CH_LF);
				default: add_byte(stok_pkg::CH_CR);
			endcase
		end
	endtask

	// string body bytes: anything but the quote, high bit and zero included
	function automatic logic [7:0] string_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == stok_pkg::CH_QUOTE)
			b = b ^ 8'h01;
		return b;
	endfunction

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------

	initial begin
		int           n;
		int           pick;
		logic [7:0]   b;
		err_trigger_t trig;

		arst_n = 1'b0;

		// directed: end while idle, repeated end
		add_end();
		add_end();
		// every skipped whitespace byte
		add_byte(stok_pkg::CH_TAB);
		add_byte(stok_pkg::CH_LF);
		add_byte(stok_pkg::CH_CR);
		add_byte(stok_pkg::CH_SPACE);
		// end inside an integer gives integer and end of input
		add_byte(stok_pkg::CH_0);
		add_end();
		// one past the top saturates, a letter right after closes the integer
		add_text("2147483648");
		add_byte(stok_pkg::CH_UA);
		add_byte(stok_pkg::CH_UZ);
		add_byte(stok_pkg::CH_COLON);
		add_byte(stok_pkg::CH_LZ);
		// digit closes the symbol and opens an integer, quote closes that
		add_byte(stok_pkg::CH_9);
		add_byte(stok_pkg::CH_QUOTE);
		// zero byte and all-ones byte inside a string are plain content
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(stok_pkg::CH_QUOTE);
		add_byte(stok_pkg::CH_LA);
		// end inside a symbol gives symbol end and end of input
		add_end();

		// random well-formed scripts
		n = pending_bytes.size() + RANDOM_ITEMS;
		while (pending_bytes.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				int len;
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
				repeat (len) add_byte(stok_pkg::CH_0 + 8'($urandom_range(0, 9)));
			end else if (pick < 60) begin
				int len;
				add_letter();
				len = $urandom_range(0, 6);
				repeat (len) begin
					if ($urandom_range(0, 4) == 0)
						add_byte(stok_pkg::CH_COLON);
					else
						add_letter();
				end
			end else if (pick < 82) begin
				int len;
				add_byte(stok_pkg::CH_QUOTE);
				len = $urandom_range(0, 8);
				repeat (len) add_byte(string_byte());
				add_byte(stok_pkg::CH_QUOTE);
			end else if (pick < 92) begin
				add_spaces();
			end else begin
				add_end();
			end
			// tokens often abut, so one token's end byte opens the next
			if ($urandom_range(0, 99) < 55)
				add_spaces();
		end

		// closing stretch: one way into the sticky error, then noise
		add_byte(stok_pkg::CH_SPACE);
		trig = err_trigger_t'($urandom_range(0, 3));
		case (trig)
			TRIG_OPEN_STRING: begin
				add_byte(stok_pkg::CH_QUOTE);
				add_byte(string_byte());
				add_end();
			end
			TRIG_ZERO_BYTE: begin
				add_byte(8'h00);
			end
			TRIG_ILLEGAL: begin
				b = 8'($urandom_range(0, 255));
				while (is_space(b) || is_digit(b) || is_letter(b) || b == stok_pkg::CH_QUOTE)
					b = 8'($urandom_range(0, 255));
				add_byte(b);
			end
			default: begin
				add_byte(stok_pkg::CH_COLON);
			end
		endcase
		repeat (16) begin
			if ($urandom_range(0, 3) == 0)
				add_end();
			else
				add_byte(8'($urandom_range(0, 255)));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the last script transaction, then for its events
		while (pending_bytes.size() != 0 || script_if.valid)
			@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_events.size() != 0)
			$error("%0d expected events never arrived", expected_events.size());
		if (failures == 0 && expected_events.size() == 0) begin
			$display("script_token_scanner regression: pass");
		end else begin
			$display("script_token_scanner regression: fail");
		end
		$finish;
	end

	// ---------------------------------------------------------------
	// script driver: bursts of random length with random gaps
	// ---------------------------------------------------------------

	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			script_if.valid    <= 1'b0;
			script_if.char_in  <= '0;
			script_if.end_mark <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
			tok_mode   = SCAN_IDLE;
			tok_accum  = '0;
		end else begin
			if (script_if.valid && script_if.ready) begin
				predict_tokens(script_if.char_in, script_if.end_mark);
				void'(pending_bytes.pop_front());
			end
			if (script_if.valid && !script_if.ready) begin
				// transaction still on offer, hold it
			end else if (gap_left > 0) begin
				gap_left--;
				script_if.valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				script_if.valid    <= 1'b1;
				script_if.char_in  <= pending_bytes[0].ch;
				script_if.end_mark <= pending_bytes[0].fin;
				if (burst_left <= 1) begin
					// now and then a long stretch with no idling at all
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
						: $urandom_range(0, 3);
				end else begin
					burst_left--;
				end
			end else begin
				script_if.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// event monitor and receiver stall pattern
	// ---------------------------------------------------------------

	int ready_phase;
	int mon_cycles;
	int hold_left;
	bit hold_done;

	always @(posedge clk or negedge arst_n) begin
		stok_pkg::result_t want;
		if (!arst_n) begin
			events_if.ready <= 1'b0;
			ready_phase = 0;
			mon_cycles  = 0;
			hold_left   = 0;
			hold_done   = 1'b0;
		end else begin
			mon_cycles++;
			if (events_if.valid && events_if.ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event transaction: event_kind %0d event_value %0d",
						events_if.event_kind, events_if.event_value);
					failures++;
				end else begin
					want = expected_events.pop_front();
					if (events_if.event_kind !== want.kind) begin
						$error("event_kind: expected %0d, actual %0d",
							want.kind, events_if.event_kind);
						failures++;
					end
					if (events_if.event_value !== want.value) begin
						$error("event_value: expected %0d, actual %0d",
							want.value, events_if.event_value);
						failures++;
					end
					if (events_if.last_of_step !== want.last) begin
						$error("last_of_step: expected %0d, actual %0d",
							want.last, events_if.last_of_step);
						failures++;
					end
				end
			end

			// one long hold-off so the result queue fills and the script side stalls
			if (!hold_done && mon_cycles == HOLD_START) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end

			ready_phase = (ready_phase + 1) % 256;
			if (hold_left > 0) begin
				hold_left--;
				events_if.ready <= 1'b0;
			end else begin
				// the pattern rotates through four flavors of back-pressure
				case (ready_phase / 64)
					0: events_if.ready <= 1'b1;
					1: events_if.ready <= ($urandom_range(0, 3) != 0);
					2: events_if.ready <= ($urandom_range(0, 3) == 0);
					default: events_if.ready <= ready_phase[0];
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("script_token_scanner regression: fail");
			$finish;
		end
	end

endmodule
